/* hdl/spd_pkg.sv */
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants of the spectrum peak detector
// Beat layouts of both channels, the job passed from detection to the
// ratio unit, and the queue status bundle.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int INT_W   = 24;
	localparam int IDX_W   = 20;
	localparam int RATIO_W = 24;
	localparam int THR_W   = 16;

	localparam logic [THR_W-1:0] THR_RESET = 16'd1280;

	typedef struct packed {
		logic [INT_W-1:0] intensity;
		logic [INT_W-1:0] noise_level;
		logic             last_sample;
	} in_beat_t;

	typedef struct packed {
		logic [IDX_W-1:0]   peak_index;
		logic [INT_W-1:0]   peak_intensity;
		logic [RATIO_W-1:0] peak_ratio;
		logic               last_peak;
	} out_beat_t;

	// one decision for the back end: a candidate, or the end of a spectrum
	typedef struct packed {
		logic             end_mark;
		logic [IDX_W-1:0] index;
		logic [INT_W-1:0] intensity;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* hdl/spd_front.sv */
// ----------------------------------------------------------------------------
// spd_front: slope test and noise window bookkeeping
// Finds local maxima, keeps a running noise prefix sum, and hands each
// candidate with its window sum to the queue once the window is complete.
// Drains pending candidates after the last sample, then clears.
// ----------------------------------------------------------------------------
module spd_front
	import spd_pkg::*;
#(
	parameter int WINDOW_SIZE = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  in_beat_t                               in_data,
	output logic                                   push,
	output job_t                                   push_job,
	output logic [INT_W+$clog2(WINDOW_SIZE+1)-1:0] push_sum,
	input  q_stat_t                                q_stat
);

	localparam int HALF   = WINDOW_SIZE / 2;
	localparam int DECIDE = (HALF > 1) ? HALF - 1 : 1;
	localparam int PLEN   = HALF + 2;
	localparam int SUM_W  = INT_W + $clog2(WINDOW_SIZE + 1);
	localparam int FCW    = $clog2(DECIDE + 1);

	logic [INT_W-1:0]        prev_int_q;
	logic signed [INT_W:0]   prev_slope_q;
	logic                    have_prev_q;
	logic [IDX_W-1:0]        cnt_q;
	logic [SUM_W-1:0]        cum_q;
	logic [SUM_W-1:0]        pfx_q [PLEN];
	logic                    cflag_q [DECIDE];
	logic [INT_W-1:0]        cint_q [DECIDE];
	logic [IDX_W-1:0]        cidx_q [DECIDE];
	logic [SUM_W-1:0]        cbase_q [DECIDE];
	logic                    flush_q;
	logic [FCW-1:0]          fcnt_q;

	logic                    acc;
	logic                    step;
	logic                    flush_done;
	logic signed [INT_W:0]   slope;
	logic                    s_neg, s_zero, p_neg, p_zero;
	logic                    new_cand;
	logic [SUM_W-1:0]        cum_nx;
	logic [SUM_W-1:0]        sel_sum;
	logic                    cflag_nx [DECIDE];
	logic [INT_W-1:0]        cint_nx [DECIDE];
	logic [IDX_W-1:0]        cidx_nx [DECIDE];
	logic [SUM_W-1:0]        cbase_nx [DECIDE];

	assign in_stall   = flush_q | q_stat.full;
	assign acc        = in_valid & ~in_stall;
	assign step       = flush_q & ~q_stat.full;
	assign flush_done = step & (fcnt_q == FCW'(DECIDE - 1));

	assign slope  = $signed({1'b0, in_data.intensity}) - $signed({1'b0, prev_int_q});
	assign s_neg  = slope[INT_W];
	assign s_zero = (slope == '0);
	assign p_neg  = prev_slope_q[INT_W];
	assign p_zero = (prev_slope_q == '0);
	// slope changes sign (or touches zero) and is falling
	assign new_cand = have_prev_q
		& (((s_neg | s_zero) & ~p_neg) | (~s_neg & (p_neg | p_zero)))
		& (slope < prev_slope_q);

	assign cum_nx = cum_q + SUM_W'(in_data.noise_level);

	always_comb begin
		cflag_nx[0] = acc & new_cand;
		cint_nx[0]  = prev_int_q;
		cidx_nx[0]  = cnt_q - IDX_W'(1);
		cbase_nx[0] = pfx_q[PLEN-1];
		for (int k = 1; k < DECIDE; k++) begin
			cflag_nx[k] = cflag_q[k-1];
			cint_nx[k]  = cint_q[k-1];
			cidx_nx[k]  = cidx_q[k-1];
			cbase_nx[k] = cbase_q[k-1];
		end
	end

	// window sum = prefix now minus prefix just before the window;
	// a half window of one ends the window one sample before the newest
	assign sel_sum  = (flush_q || HALF == 1) ? cum_q : cum_nx;
	assign push_sum = sel_sum - cbase_nx[DECIDE-1];
	assign push     = (acc | step) & (cflag_nx[DECIDE-1] | flush_done);

	assign push_job.end_mark  = flush_done;
	assign push_job.index     = cidx_nx[DECIDE-1];
	assign push_job.intensity = cint_nx[DECIDE-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_int_q   <= '0;
			prev_slope_q <= '0;
			have_prev_q  <= 1'b0;
			cnt_q        <= '0;
			cum_q        <= '0;
			flush_q      <= 1'b0;
			fcnt_q       <= '0;
			for (int k = 0; k < PLEN; k++) begin
				pfx_q[k] <= '0;
			end
			for (int k = 0; k < DECIDE; k++) begin
				cflag_q[k] <= 1'b0;
			end
		end else begin
			if (acc) begin
				prev_int_q  <= in_data.intensity;
				have_prev_q <= 1'b1;
				if (have_prev_q) begin
					prev_slope_q <= slope;
				end
				cnt_q    <= cnt_q + IDX_W'(1);
				cum_q    <= cum_nx;
				pfx_q[0] <= cum_nx;
				for (int k = 1; k < PLEN; k++) begin
					pfx_q[k] <= pfx_q[k-1];
				end
				if (in_data.last_sample) begin
					flush_q <= 1'b1;
					fcnt_q  <= '0;
				end
			end
			if (acc | step) begin
				for (int k = 0; k < DECIDE; k++) begin
					cflag_q[k] <= cflag_nx[k];
				end
			end
			if (step) begin
				fcnt_q <= fcnt_q + FCW'(1);
			end
			if (flush_done) begin
				// spectrum over: back to the after-reset state
				flush_q      <= 1'b0;
				prev_int_q   <= '0;
				prev_slope_q <= '0;
				have_prev_q  <= 1'b0;
				cnt_q        <= '0;
				cum_q        <= '0;
				for (int k = 0; k < PLEN; k++) begin
					pfx_q[k] <= '0;
				end
				for (int k = 0; k < DECIDE; k++) begin
					cflag_q[k] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc | step) begin
			for (int k = 0; k < DECIDE; k++) begin
				cint_q[k]  <= cint_nx[k];
				cidx_q[k]  <= cidx_nx[k];
				cbase_q[k] <= cbase_nx[k];
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("job pushed into full queue");

	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_data.last_sample |=> flush_q && in_stall)
		else $error("drain did not start after last sample");

endmodule

/* hdl/spd_queue.sv */
// ----------------------------------------------------------------------------
// spd_queue: small job FIFO between detection and ratio unit
// Register based, one push and one pop per cycle.
// ----------------------------------------------------------------------------
module spd_queue
	import spd_pkg::*;
#(
	parameter int WIDTH = 75,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output q_stat_t          q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	assign pop_data     = mem_q[rd_q];
	assign q_stat.full  = (cnt_q == CW'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count past depth");

endmodule

/* hdl/spd_back.sv */
// ----------------------------------------------------------------------------
// spd_back: SNR gate, ratio divider and last-peak hold
// Tests intensity*W*256 >= threshold*S, divides one quotient bit per cycle,
// and keeps the newest passed peak back until the next one or the end mark.
// ----------------------------------------------------------------------------
module spd_back
	import spd_pkg::*;
#(
	parameter int WINDOW_SIZE = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  q_stat_t                                q_stat,
	output logic                                   pop,
	input  job_t                                   pop_job,
	input  logic [INT_W+$clog2(WINDOW_SIZE+1)-1:0] pop_sum,
	input  logic [THR_W-1:0]                       snr_threshold,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output out_beat_t                              out_data
);

	localparam int SUM_W  = INT_W + $clog2(WINDOW_SIZE + 1);
	localparam int NUM_W  = SUM_W + 8;
	localparam int PROD_W = SUM_W + THR_W;
	localparam int SAT_W  = SUM_W + RATIO_W;
	localparam int BW     = $clog2(RATIO_W);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_CHECK,
		S_DIV,
		S_EMIT
	} state_t;

	state_t             state_q;
	logic               end_q;
	logic [IDX_W-1:0]   idx_q;
	logic [INT_W-1:0]   int_q;
	logic [SUM_W-1:0]   sum_q;
	logic [NUM_W-1:0]   num_q;
	logic [PROD_W-1:0]  prod_q;
	logic [SUM_W-1:0]   rem_q;
	logic [RATIO_W-1:0] dvd_q;
	logic [BW-1:0]      bit_q;
	logic               held_valid_q;
	logic [IDX_W-1:0]   held_idx_q;
	logic [INT_W-1:0]   held_int_q;
	logic [RATIO_W-1:0] held_ratio_q;
	logic               out_valid_q;
	out_beat_t          out_q;

	logic               out_free;
	logic               emit_ok;
	logic               pass;
	logic               sat;
	logic [SUM_W:0]     rem_sh;
	logic               ge;
	logic [SUM_W-1:0]   rem_nx;

	assign pop       = (state_q == S_IDLE) & ~q_stat.empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign emit_ok   = ~held_valid_q | out_free;

	// zero window sum passes and saturates without a special case
	assign pass = (PROD_W'(num_q) >= prod_q);
	assign sat  = (SAT_W'(num_q) >= {sum_q, {RATIO_W{1'b0}}});

	assign rem_sh = {rem_q, dvd_q[RATIO_W-1]};
	assign ge     = (rem_sh >= {1'b0, sum_q});
	assign rem_nx = ge ? SUM_W'(rem_sh - {1'b0, sum_q}) : rem_sh[SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			end_q        <= 1'b0;
			idx_q        <= '0;
			int_q        <= '0;
			sum_q        <= '0;
			num_q        <= '0;
			prod_q       <= '0;
			rem_q        <= '0;
			dvd_q        <= '0;
			bit_q        <= '0;
			held_valid_q <= 1'b0;
			held_idx_q   <= '0;
			held_int_q   <= '0;
			held_ratio_q <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						end_q   <= pop_job.end_mark;
						idx_q   <= pop_job.index;
						int_q   <= pop_job.intensity;
						sum_q   <= pop_sum;
						state_q <= pop_job.end_mark ? S_EMIT : S_PREP;
					end
				end
				S_PREP: begin
					prod_q  <= PROD_W'(snr_threshold) * PROD_W'(sum_q);
					num_q   <= {(NUM_W-8)'(int_q) * (NUM_W-8)'(WINDOW_SIZE), 8'h00};
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!pass) begin
						state_q <= S_IDLE;
					end else if (sat) begin
						dvd_q   <= '1;
						state_q <= S_EMIT;
					end else begin
						// quotient fits RATIO_W bits: high part is the start remainder
						rem_q   <= SUM_W'(num_q >> RATIO_W);
						dvd_q   <= num_q[RATIO_W-1:0];
						bit_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= rem_nx;
					dvd_q <= {dvd_q[RATIO_W-2:0], ge};
					bit_q <= bit_q + BW'(1);
					if (bit_q == BW'(RATIO_W - 1)) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_ok) begin
						if (held_valid_q) begin
							out_valid_q          <= 1'b1;
							out_q.peak_index     <= held_idx_q;
							out_q.peak_intensity <= held_int_q;
							out_q.peak_ratio     <= held_ratio_q;
							out_q.last_peak      <= end_q;
						end
						if (end_q) begin
							held_valid_q <= 1'b0;
						end else begin
							held_valid_q <= 1'b1;
							held_idx_q   <= idx_q;
							held_int_q   <= int_q;
							held_ratio_q <= dvd_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < sum_q)
		else $error("divider remainder not below divisor");

	a_end_clears_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && emit_ok && end_q |=> !held_valid_q && state_q == S_IDLE)
		else $error("held peak survived end of spectrum");

endmodule

/* hdl/spectrum_peak_detect_snr.sv */
// ----------------------------------------------------------------------------
// spectrum_peak_detect_snr: streaming peak picker with SNR gate
// Local maxima of an intensity stream, kept when intensity over the mean of
// a WINDOW_SIZE noise window meets the Q8.8 threshold.
//  - in channel: one spectrum sample per beat; last_sample closes the spectrum.
//  - out channel: one passed peak per beat (index, intensity, Q16.8 ratio,
//    last_peak on the final peak of the spectrum).
//  - snr_threshold: write cfg_wdata with cfg_we high, only while idle.
//  - Input: one beat per cycle while the job queue is not full. After a
//    last_sample beat the input stalls until the pending candidates drain.
//  - Ratio unit per candidate: pop, multiply, compare, 24 divide steps,
//    emit if it passes; no divide steps if the ratio saturates, no emit if
//    it fails. Close passing peaks fill the queue and stall the input.
//  - A peak is decided WINDOW_SIZE/2-1 samples after it arrives (1 below 4)
//    and leaves when the next peak passes or the spectrum ends.
//  - out_stall holds the output register; the ratio unit waits on it while
//    the queue absorbs detection.
//  - Reset clears all spectrum state and loads threshold 5.0 (1280).
// ----------------------------------------------------------------------------
module spectrum_peak_detect_snr
	import spd_pkg::*;
#(
	parameter int WINDOW_SIZE = 32,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_beat_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_beat_t        out_data,
	input  logic             cfg_we,
	input  logic [THR_W-1:0] cfg_wdata
);

	// window sums need log2(W+1) bits above the sample width
	localparam int SUM_W = INT_W + $clog2(WINDOW_SIZE + 1);
	localparam int JOB_W = $bits(job_t) + SUM_W;

	logic [THR_W-1:0] thr_q;

	logic             push;
	job_t             push_job;
	logic [SUM_W-1:0] push_sum;
	logic             pop;
	logic [JOB_W-1:0] pop_data;
	job_t             pop_job;
	logic [SUM_W-1:0] pop_sum;
	q_stat_t          q_stat;

	// threshold register; the user writes it only between spectra, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// detection: slope test, prefix sums, candidate delay line
	spd_front #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.push     (push),
		.push_job (push_job),
		.push_sum (push_sum),
		.q_stat   (q_stat)
	);

	// decouples the front, one sample per cycle unless stalled, from the slow ratio unit
	spd_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_job, push_sum}),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	assign pop_job = job_t'(pop_data[JOB_W-1:SUM_W]);
	assign pop_sum = pop_data[SUM_W-1:0];

	// SNR gate, divider, held peak and output register
	spd_back #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.pop           (pop),
		.pop_job       (pop_job),
		.pop_sum       (pop_sum),
		.snr_threshold (thr_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data)
	);

endmodule
